// ===== src/hbp_pkg.sv =====
// Shared types and constants of the hybrid branch predictor core.
// Used by hbp_ctrl, hbp_datapath and hybrid_branch_predictor_core.
`default_nettype none

package hbp_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MODE         = 3'd0;
   localparam logic [2:0] CSR_BIMODAL_BITS = 3'd1;
   localparam logic [2:0] CSR_GSHARE_BITS  = 3'd2;
   localparam logic [2:0] CSR_HISTORY_BITS = 3'd3;
   localparam logic [2:0] CSR_CHOOSER_BITS = 3'd4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 4;

   // Predictor modes. Code 3 acts as hybrid.
   localparam logic [1:0] MODE_BIMODAL = 2'd0;
   localparam logic [1:0] MODE_GSHARE  = 2'd1;
   localparam logic [1:0] MODE_HYBRID  = 2'd2;

   // Reset contents of the counter tables.
   localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
   localparam logic [1:0] CTR_CHOOSER_INIT = 2'd1;
   localparam logic [1:0] CTR_MAX = 2'd3;
   localparam logic [1:0] CTR_MIN = 2'd0;

   typedef struct packed {
      logic [31:0] branch_address;
      logic        taken;
   } req_payload_type;

   typedef struct packed {
      logic        predicted_taken;
      logic        mispredicted;
      logic        used_gshare;
      logic [31:0] miss_count;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic lookup;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } status_type;

   // Two-bit saturating counter step.
   function automatic logic [1:0] train(input logic [1:0] ctr, input logic up);
      logic [1:0] result;
      if (up) begin
         result = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
      end else begin
         result = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== src/hybrid_branch_predictor_core.sv =====
// Top level of the hybrid branch predictor core (bimodal, gshare, chooser).
// Depends on hbp_pkg, hbp_ctrl and hbp_datapath.
//
//   Port group  Direction  Handshake            Payload
//   req_*       in         req_valid/req_ready  hbp_pkg::req_payload_type
//   rsp_*       out        rsp_valid/rsp_ready  hbp_pkg::rsp_payload_type
//   csr_*       in         csr_we               csr_index, csr_wdata
//
// Each branch passes the transfer into the input register, the registered
// reads of the three counter tables and the update that trains the tables,
// shifts the history outside bimodal mode and loads the output register.
// After reset the block sweeps all 2**MAX_INDEX_BITS entries of the three
// tables, one per cycle, with req_ready low; configuration writes
// are taken during the sweep. A new branch is accepted while the previous
// result still waits in the output register; only a second finished result
// stalls, holding in the update cycle until rsp_ready frees the register.
`default_nettype none

module hybrid_branch_predictor_core #(
   parameter int MAX_INDEX_BITS = 14
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire hbp_pkg::req_payload_type             req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output hbp_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                 csr_we,
   input  wire logic [hbp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [hbp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import hbp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences the clearing sweep and each transfer; it owns
   // the output valid flag.
   hbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the settings, the tables, the global history and the
   // saturating miss total.
   hbp_datapath #(
      .MAX_INDEX_BITS (MAX_INDEX_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== src/hbp_ctrl.sv =====
// Controller state machine of the hybrid branch predictor core.
// Depends on hbp_pkg; drives hbp_datapath through cmd_type.
`default_nettype none

module hbp_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output hbp_pkg::cmd_type        cmd,
   input  wire hbp_pkg::status_type status
);
   import hbp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Results commit only once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/hbp_datapath.sv =====
// Datapath of the hybrid branch predictor core: settings, counter tables,
// history, miss total and output register. Depends on hbp_pkg.
`default_nettype none

module hbp_datapath #(
   parameter int MAX_INDEX_BITS = 14
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire hbp_pkg::cmd_type                     cmd,
   output hbp_pkg::status_type                       status,
   input  wire logic                                 csr_we,
   input  wire logic [hbp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [hbp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  wire hbp_pkg::req_payload_type             req_payload,
   output hbp_pkg::rsp_payload_type                  rsp_payload
);
   import hbp_pkg::*;

   localparam int DEPTH = 1 << MAX_INDEX_BITS;
   localparam int IW    = $clog2(MAX_INDEX_BITS + 1);
   localparam int MI    = MAX_INDEX_BITS;

   function automatic logic [IW-1:0] clamp_bits(input logic [CSR_DATA_WIDTH-1:0] raw);
      logic [31:0]   wide;
      logic [IW-1:0] result;
      wide = 32'(raw);
      if (wide == 32'd0) begin
         result = IW'(1);
      end else if (wide > 32'(MAX_INDEX_BITS)) begin
         result = IW'(MAX_INDEX_BITS);
      end else begin
         result = IW'(wide);
      end
      return result;
   endfunction

   function automatic logic [MI-1:0] low_mask(input logic [IW-1:0] bits);
      return ~({MI{1'b1}} << bits);
   endfunction

   // Settings.
   logic [1:0]                mode_ff;
   logic [CSR_DATA_WIDTH-1:0] bim_bits_ff;
   logic [CSR_DATA_WIDTH-1:0] gsh_bits_ff;
   logic [CSR_DATA_WIDTH-1:0] hist_bits_ff;
   logic [CSR_DATA_WIDTH-1:0] cho_bits_ff;

   // Architectural state and captured item.
   logic [MI-1:0] clr_cnt_ff;
   logic [MI-1:0] hist_ff;
   logic [MI-1:0] hist_in;
   logic [31:0]   miss_ff;
   logic [31:0]   miss_in;
   logic [MI-1:0] word_ff;
   logic          taken_ff;

   // Counter tables and their registered read data.
   logic [1:0] bim_mem [DEPTH];
   logic [1:0] gsh_mem [DEPTH];
   logic [1:0] cho_mem [DEPTH];
   logic [1:0] bim_rd_ff;
   logic [1:0] gsh_rd_ff;
   logic [1:0] cho_rd_ff;

   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;

   logic [IW-1:0] m2, m1, n_raw, n, k, low;
   logic [MI-1:0] bi_idx, gs_idx, ch_idx;
   logic          bi_pred, gs_pred, use_gs, pred, miss;
   logic          bi_ok, gs_ok;
   logic          bim_we, gsh_we, cho_we;
   logic [MI-1:0] bim_wa, gsh_wa, cho_wa;
   logic [1:0]    bim_wd, gsh_wd, cho_wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BIMODAL;
         bim_bits_ff  <= 4'd6;
         gsh_bits_ff  <= 4'd9;
         hist_bits_ff <= 4'd3;
         cho_bits_ff  <= 4'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:         mode_ff      <= csr_wdata[1:0];
            CSR_BIMODAL_BITS: bim_bits_ff  <= csr_wdata;
            CSR_GSHARE_BITS:  gsh_bits_ff  <= csr_wdata;
            CSR_HISTORY_BITS: hist_bits_ff <= csr_wdata;
            CSR_CHOOSER_BITS: cho_bits_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Index computation.
   always_comb begin
      m2     = clamp_bits(bim_bits_ff);
      m1     = clamp_bits(gsh_bits_ff);
      n_raw  = clamp_bits(hist_bits_ff);
      k      = clamp_bits(cho_bits_ff);
      n      = (n_raw > m1) ? m1 : n_raw;
      low    = m1 - n;
      bi_idx = word_ff & low_mask(m2);
      gs_idx = (word_ff & low_mask(m1)) ^ ((hist_ff & low_mask(n)) << low);
      ch_idx = word_ff & low_mask(k);
   end

   // Prediction, training and results.
   always_comb begin
      bi_pred = bim_rd_ff[1];
      gs_pred = gsh_rd_ff[1];
      case (mode_ff)
         MODE_BIMODAL: use_gs = 1'b0;
         MODE_GSHARE:  use_gs = 1'b1;
         default:      use_gs = cho_rd_ff[1];
      endcase
      pred  = use_gs ? gs_pred : bi_pred;
      miss  = pred != taken_ff;
      bi_ok = bi_pred == taken_ff;
      gs_ok = gs_pred == taken_ff;

      hist_in = hist_ff;
      if (mode_ff != MODE_BIMODAL) begin
         hist_in = hist_ff >> 1;
         if (taken_ff) begin
            hist_in = hist_in | (MI'(1) << (n - IW'(1)));
         end
      end

      miss_in = (miss && (miss_ff != 32'hFFFF_FFFF)) ? miss_ff + 32'd1 : miss_ff;

      rsp_in.predicted_taken = pred;
      rsp_in.mispredicted    = miss;
      rsp_in.used_gshare     = use_gs;
      rsp_in.miss_count      = miss_in;

      if (cmd.clear_step) begin
         bim_we = 1'b1;
         gsh_we = 1'b1;
         cho_we = 1'b1;
         bim_wa = clr_cnt_ff;
         gsh_wa = clr_cnt_ff;
         cho_wa = clr_cnt_ff;
         bim_wd = CTR_WEAK_TAKEN;
         gsh_wd = CTR_WEAK_TAKEN;
         cho_wd = CTR_CHOOSER_INIT;
      end else begin
         bim_we = cmd.commit && !use_gs;
         gsh_we = cmd.commit && use_gs;
         cho_we = cmd.commit && mode_ff[1] && (gs_ok != bi_ok);
         bim_wa = bi_idx;
         gsh_wa = gs_idx;
         cho_wa = ch_idx;
         bim_wd = train(bim_rd_ff, taken_ff);
         gsh_wd = train(gsh_rd_ff, taken_ff);
         cho_wd = train(cho_rd_ff, gs_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (bim_we) begin
         bim_mem[bim_wa] <= bim_wd;
      end
      if (cmd.lookup) begin
         bim_rd_ff <= bim_mem[bi_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (gsh_we) begin
         gsh_mem[gsh_wa] <= gsh_wd;
      end
      if (cmd.lookup) begin
         gsh_rd_ff <= gsh_mem[gs_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cho_we) begin
         cho_mem[cho_wa] <= cho_wd;
      end
      if (cmd.lookup) begin
         cho_rd_ff <= cho_mem[ch_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         hist_ff    <= '0;
         miss_ff    <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + MI'(1);
         end
         if (cmd.commit) begin
            hist_ff <= hist_in;
            miss_ff <= miss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff  <= req_payload.branch_address[MI+1:2];
         taken_ff <= req_payload.taken;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.clear_last = &clr_cnt_ff;
   assign rsp_payload       = rsp_ff;

endmodule

`default_nettype wire

// ===== test/hbp_prediction_checker.sv =====
`timescale 1ns / 100ps
// Checker for the hybrid branch predictor core: keeps its own copy of the counter tables,
// history and registers, predicts each result and compares it with the result transfers.
// Depends on hbp_pkg for the payload types and the register and mode codes.

module hbp_prediction_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire hbp_pkg::req_payload_type             req_payload,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire hbp_pkg::rsp_payload_type             rsp_payload,
   input  wire logic                                 csr_we,
   input  wire logic [hbp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [hbp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output int                                        outstanding,
   output int                                        mismatch_count
);
   import hbp_pkg::*;

   localparam int INDEX_BITS = 14;
   localparam int DEPTH = 1 << INDEX_BITS;
   localparam int REPORT_LIMIT = 10;
   // Counters at or above this value vote taken, and a chooser at or above it picks gshare.
   localparam logic [1:0] UPPER_HALF = 2'd2;

   logic [1:0]            mode_reg;
   logic [3:0]            bimodal_width_reg;
   logic [3:0]            gshare_width_reg;
   logic [3:0]            history_width_reg;
   logic [3:0]            chooser_width_reg;
   logic [1:0]            bimodal_ctr [DEPTH];
   logic [1:0]            gshare_ctr [DEPTH];
   logic [1:0]            chooser_ctr [DEPTH];
   logic [INDEX_BITS-1:0] history;
   logic [31:0]           miss_total;
   rsp_payload_type       expected_outcomes [$];

   function automatic int effective_width(input logic [3:0] w);
      if (w == 4'd0) return 1;
      if (int'(w) > INDEX_BITS) return INDEX_BITS;
      return int'(w);
   endfunction

   function automatic logic [31:0] width_mask(input int w);
      return (32'd1 << w) - 32'd1;
   endfunction

   function automatic logic [1:0] saturate_step(input logic [1:0] ctr, input logic up);
      if (up) return (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
      return (ctr == CTR_MIN) ? ctr : ctr - 2'd1;
   endfunction

   // Works out the result of one resolved branch and trains the local tables.
   function automatic rsp_payload_type predict_branch(input req_payload_type br);
      logic [31:0] word;
      int          bim_w, gsh_w, hist_w, cho_w;
      int unsigned bim_idx, gsh_idx, cho_idx;
      logic        bim_taken, gsh_taken, pick_gshare, guess;
      word   = br.branch_address >> 2;
      bim_w  = effective_width(bimodal_width_reg);
      gsh_w  = effective_width(gshare_width_reg);
      hist_w = effective_width(history_width_reg);
      cho_w  = effective_width(chooser_width_reg);
      if (hist_w > gsh_w) hist_w = gsh_w;
      bim_idx = word & width_mask(bim_w);
      gsh_idx = (word & width_mask(gsh_w))
              ^ ((32'(history) & width_mask(hist_w)) << (gsh_w - hist_w));
      cho_idx = word & width_mask(cho_w);

      bim_taken = bimodal_ctr[bim_idx] >= UPPER_HALF;
      gsh_taken = gshare_ctr[gsh_idx] >= UPPER_HALF;
      case (mode_reg)
         MODE_BIMODAL: pick_gshare = 1'b0;
         MODE_GSHARE:  pick_gshare = 1'b1;
         default:      pick_gshare = chooser_ctr[cho_idx] >= UPPER_HALF;
      endcase
      guess = pick_gshare ? gsh_taken : bim_taken;

      if (pick_gshare) gshare_ctr[gsh_idx] = saturate_step(gshare_ctr[gsh_idx], br.taken);
      else bimodal_ctr[bim_idx] = saturate_step(bimodal_ctr[bim_idx], br.taken);

      if (mode_reg != MODE_BIMODAL) begin
         history = history >> 1;
         if (br.taken) history[hist_w-1] = 1'b1;
      end

      // The chooser leans toward whichever table alone was right.
      if (mode_reg >= MODE_HYBRID && ((gsh_taken == br.taken) != (bim_taken == br.taken)))
         chooser_ctr[cho_idx] = saturate_step(chooser_ctr[cho_idx], gsh_taken == br.taken);

      if (guess != br.taken && miss_total != 32'hFFFF_FFFF) miss_total = miss_total + 32'd1;

      return '{predicted_taken: guess, mispredicted: guess != br.taken,
               used_gshare: pick_gshare, miss_count: miss_total};
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         mode_reg          = MODE_BIMODAL;
         bimodal_width_reg = 4'd6;
         gshare_width_reg  = 4'd9;
         history_width_reg = 4'd3;
         chooser_width_reg = 4'd8;
         for (int i = 0; i < DEPTH; i++) begin
            bimodal_ctr[i] = CTR_WEAK_TAKEN;
            gshare_ctr[i]  = CTR_WEAK_TAKEN;
            chooser_ctr[i] = CTR_CHOOSER_INIT;
         end
         history    = '0;
         miss_total = '0;
         expected_outcomes.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:         mode_reg = csr_wdata[1:0];
               CSR_BIMODAL_BITS: bimodal_width_reg = csr_wdata;
               CSR_GSHARE_BITS:  gshare_width_reg = csr_wdata;
               CSR_HISTORY_BITS: history_width_reg = csr_wdata;
               CSR_CHOOSER_BITS: chooser_width_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_outcomes.push_back(predict_branch(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: result transfer with no branch pending: pred=%0b miss=%0b gs=%0b count=%0d",
                           $time, rsp_payload.predicted_taken, rsp_payload.mispredicted,
                           rsp_payload.used_gshare, rsp_payload.miss_count);
               mismatch_count++;
            end else begin
               want = expected_outcomes.pop_front();
               if (want !== rsp_payload) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("%0t: result mismatch: expected pred=%0b miss=%0b gs=%0b count=%0d, got pred=%0b miss=%0b gs=%0b count=%0d",
                              $time, want.predicted_taken, want.mispredicted, want.used_gshare,
                              want.miss_count, rsp_payload.predicted_taken,
                              rsp_payload.mispredicted, rsp_payload.used_gshare,
                              rsp_payload.miss_count);
                  mismatch_count++;
               end
            end
         end
      end
      outstanding = expected_outcomes.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for hybrid_branch_predictor_core: clock, reset, branch and register stimulus,
// and the verdict. Depends on hbp_pkg, the core RTL and hbp_prediction_checker.

module tb_top;
   import hbp_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BRANCHES = 38;
   localparam int HOT_BRANCHES = 6;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   // The core treats the spare mode code like hybrid; the package gives it no name.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_payload_type            req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int outstanding;
   int mismatch_count;

   // Largest per-transfer wait of each side in the current phase; zero gives
   // stretches with no idling at all.
   int req_max_gap = 0;
   int rsp_max_gap = 0;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit hold_long = 1'b0;

   // A few branch sites per phase, each with its own taken bias in percent, so
   // the counters saturate, the chooser moves and the history sees patterns.
   logic [31:0] hot_address [HOT_BRANCHES];
   int unsigned taken_bias [HOT_BRANCHES];

   always #5 clock = ~clock;

   hybrid_branch_predictor_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   hbp_prediction_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   // The clearing sweep after reset covers all 16384 table entries; the rest of the
   // run stays far below this bound even with every wait at its longest.
   initial begin : watchdog
      #(5_000_000);
      $display("[hybrid_branch_predictor_core] ERROR");
      $finish;
   end

   // One register write per cycle. The enable stays high so that back-to-back
   // writes never lower and raise it in the same step; the caller lowers it.
   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [3:0] bimodal_bits,
                            input logic [3:0] gshare_bits, input logic [3:0] history_bits,
                            input logic [3:0] chooser_bits);
      csr_write(CSR_MODE, {2'b00, mode});
      csr_write(CSR_BIMODAL_BITS, bimodal_bits);
      csr_write(CSR_GSHARE_BITS, gshare_bits);
      csr_write(CSR_HISTORY_BITS, history_bits);
      csr_write(CSR_CHOOSER_BITS, chooser_bits);
      csr_we <= 1'b0;
   endtask

   // Offers one branch after a random gap and returns at the falling edge that
   // follows its transfer. Valid is only touched when its value has to change,
   // so a back-to-back branch keeps it high without a glitch in the step.
   task automatic send_branch(input logic [31:0] address, input logic outcome);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{branch_address: address, taken: outcome};
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Every branch gives exactly one result, so once none is pending the core is
   // idle and the registers may be rewritten.
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic int pick_gap_limit();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 4;
         default: return 16;
      endcase
   endfunction

   // Mostly legal widths, with the clamped codes 0 and 15 and both ends mixed in.
   function automatic logic [3:0] pick_width();
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 3))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return 4'd14;
            default: return 4'd15;
         endcase
      end
      return 4'($urandom_range(1, 14));
   endfunction

   // A random phase: most branches come from the hot sites with their bias,
   // the rest are fully random addresses and outcomes.
   task automatic run_phase(input int count, input bit squeeze);
      int          slot;
      logic [31:0] address;
      logic        outcome;
      for (int s = 0; s < HOT_BRANCHES; s++) begin
         hot_address[s] = $urandom;
         taken_bias[s]  = $urandom_range(0, 4) * 25;
      end
      if (squeeze) begin
         // The sender keeps offering while the receiver is held off, so the
         // core fills up and has to stall its input.
         req_max_gap = 0;
         hold_long   = 1'b1;
      end
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            slot    = $urandom_range(0, HOT_BRANCHES - 1);
            address = hot_address[slot];
            outcome = $urandom_range(0, 99) < taken_bias[slot];
         end else begin
            address = $urandom;
            outcome = 1'($urandom_range(0, 1));
         end
         send_branch(address, outcome);
      end
      drain();
   endtask

   // Result side: a fresh wait is drawn for every result, and a pending long
   // hold-off is served first, counted here in cycles.
   initial begin : receiver
      int stall;
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         stall = $urandom_range(0, rsp_max_gap);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Bimodal with a zero width, which acts as one bit, so the highest address
      // and 0x4 share a counter, and the lowest address trains the other one.
      configure(MODE_BIMODAL, 4'd0, 4'd9, 4'd3, 4'd8);
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      send_branch(32'hFFFF_FFFF, 1'b1);
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'h0000_0004, 1'b0);
      drain();

      // Gshare with every width but the chooser's above the maximum and the
      // chooser's at zero, so all of them clamp and the history spans the full index.
      configure(MODE_GSHARE, 4'd15, 4'd15, 4'd15, 4'd0);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'hFFFF_FFFC, 1'b0);
      send_branch(32'h0000_0000, 1'b1);
      drain();

      // History longer than the gshare index gets cut to the index width.
      configure(MODE_GSHARE, 4'd6, 4'd2, 4'd9, 4'd8);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'h0000_0004, 1'b0);
      send_branch(32'h0000_0008, 1'b1);
      send_branch(32'h0000_000C, 1'b1);
      drain();

      // Hybrid with the chooser at its widest; mixed outcomes on one
      // site make the two tables disagree and move the chooser.
      req_max_gap = 16;
      rsp_max_gap = 16;
      configure(MODE_HYBRID, 4'd14, 4'd1, 4'd1, 4'd14);
      send_branch(32'h0000_0100, 1'b0);
      send_branch(32'h0000_0100, 1'b0);
      send_branch(32'h0000_0100, 1'b0);
      send_branch(32'h0000_0100, 1'b1);
      send_branch(32'h0000_0100, 1'b0);
      drain();

      // A write to an unmapped index must change nothing; then the spare mode
      // code, which behaves like hybrid.
      csr_write(CSR_CHOOSER_BITS + 3'($urandom_range(1, 3)), 4'($urandom));
      configure(MODE_SPARE, 4'd6, 4'd9, 4'd3, 4'd8);
      send_branch(32'h8000_0000, 1'b1);
      send_branch(32'h7FFF_FFFC, 1'b0);
      send_branch(32'h0000_0010, 1'b1);
      send_branch(32'h0000_0010, 1'b1);
      drain();

      // Random phases, each with its own register setting and idle pattern.
      // The first two pin all widths to the top and to the bottom.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0)
            configure(MODE_HYBRID, 4'd14, 4'd14, 4'd14, 4'd14);
         else if (ph == 1)
            configure(MODE_HYBRID, 4'd1, 4'd1, 4'd1, 4'd1);
         else
            configure(2'($urandom_range(0, 3)), pick_width(), pick_width(), pick_width(),
                      pick_width());
         req_max_gap = pick_gap_limit();
         rsp_max_gap = pick_gap_limit();
         run_phase(PHASE_BRANCHES, ph == 3 || ph == 7);
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("[hybrid_branch_predictor_core] OK");
      end else begin
         $display("[hybrid_branch_predictor_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hbp_pkg.sv
src/hbp_ctrl.sv
src/hbp_datapath.sv
src/hybrid_branch_predictor_core.sv
test/hbp_prediction_checker.sv
test/tb_top.sv
